@@ src/mfsp_pkg.sv @@
`default_nettype none
package mfsp_pkg;

	localparam int unsigned TIME_WIDTH_DEF = 32;
	localparam int unsigned QUEUE_DEPTH    = 4;
	localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	// result kinds
	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_CHANNEL = 3'd1;
	localparam logic [2:0] KIND_META    = 3'd2;
	localparam logic [2:0] KIND_SYSEX   = 3'd3;
	localparam logic [2:0] KIND_PAYLOAD = 3'd4;
	localparam logic [2:0] KIND_TRACK   = 3'd5;
	localparam logic [2:0] KIND_ERROR   = 3'd6;

	// error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_HDR    = 2'd1;
	localparam logic [1:0] ERR_CHUNK  = 2'd2;
	localparam logic [1:0] ERR_STATUS = 2'd3;

	// status bytes
	localparam logic [7:0] ST_SYSEX  = 8'hF0;
	localparam logic [7:0] ST_ESCAPE = 8'hF7;
	localparam logic [7:0] ST_META   = 8'hFF;
	localparam logic [3:0] HI_PROG   = 4'hC;
	localparam logic [3:0] HI_PRESS  = 4'hD;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] track_number;
		logic [31:0] delta_ticks;
		logic [31:0] absolute_ticks;
		logic [7:0]  status_byte;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic [31:0] payload_length;
		logic [1:0]  error_code;
		logic [15:0] file_format;
		logic [15:0] tick_division;
		logic        last_payload;
	} result_t;

	// header magic: "MThd" and length 6
	function automatic logic [7:0] hdr_magic(input logic [2:0] i);
		logic [7:0] v;
		case (i)
			3'd0:    v = 8'h4D;
			3'd1:    v = 8'h54;
			3'd2:    v = 8'h68;
			3'd3:    v = 8'h64;
			3'd7:    v = 8'h06;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// track magic: "MTrk"
	function automatic logic [7:0] trk_magic(input logic [1:0] i);
		logic [7:0] v;
		case (i)
			2'd0:    v = 8'h4D;
			2'd1:    v = 8'h54;
			2'd2:    v = 8'h72;
			default: v = 8'h6B;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

@@ src/mfsp_parser.sv @@
`default_nettype none
module mfsp_parser #(
	parameter int unsigned TIME_WIDTH = mfsp_pkg::TIME_WIDTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire logic [7:0]      in_byte,
	output mfsp_pkg::result_t    res,
	output logic                 res_valid
);

	typedef enum logic [12:0] {
		PH_HDR    = 13'b0000000000001,
		PH_CMAGIC = 13'b0000000000010,
		PH_CLEN   = 13'b0000000000100,
		PH_DELTA  = 13'b0000000001000,
		PH_STATUS = 13'b0000000010000,
		PH_DATA1  = 13'b0000000100000,
		PH_DATA2  = 13'b0000001000000,
		PH_MTYPE  = 13'b0000010000000,
		PH_MLEN   = 13'b0000100000000,
		PH_MDATA  = 13'b0001000000000,
		PH_XLEN   = 13'b0010000000000,
		PH_XDATA  = 13'b0100000000000,
		PH_HALT   = 13'b1000000000000
	} phase_t;

	phase_t                phase_q, phase_n;
	logic [3:0]            bcnt_q, bcnt_n;
	logic [31:0]           chunk_q, chunk_n, chunk_dec;
	logic [TIME_WIDTH-1:0] vlq_q, vlq_n, vlq_take;
	logic [7:0]            rs_q, rs_n;
	logic [TIME_WIDTH-1:0] clock_q, clock_n;
	logic [15:0]           trk_q, trk_n;
	logic [TIME_WIDTH-1:0] delta_q, delta_n;
	logic [7:0]            held_q, held_n;
	logic [TIME_WIDTH-1:0] pay_q, pay_n;
	logic [15:0]           hfmt_q, hfmt_n;
	logic [15:0]           htrk_q, htrk_n;
	logic                  in_track;
	logic                  is_meta;

	// hold state and event bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			bcnt_q  <= '0;
			chunk_q <= '0;
			vlq_q   <= '0;
			rs_q    <= '0;
			clock_q <= '0;
			trk_q   <= '0;
			delta_q <= '0;
			held_q  <= '0;
			pay_q   <= '0;
			hfmt_q  <= '0;
			htrk_q  <= '0;
		end else if (take) begin
			phase_q <= phase_n;
			bcnt_q  <= bcnt_n;
			chunk_q <= chunk_n;
			vlq_q   <= vlq_n;
			rs_q    <= rs_n;
			clock_q <= clock_n;
			trk_q   <= trk_n;
			delta_q <= delta_n;
			held_q  <= held_n;
			pay_q   <= pay_n;
			hfmt_q  <= hfmt_n;
			htrk_q  <= htrk_n;
		end
	end

	assign in_track = (phase_q != PH_HDR) && (phase_q != PH_CMAGIC) &&
		(phase_q != PH_CLEN) && (phase_q != PH_HALT);
	assign chunk_dec = (in_track && chunk_q != '0) ? chunk_q - 32'd1 : chunk_q;
	assign vlq_take  = {vlq_q[TIME_WIDTH-8:0], in_byte[6:0]};
	assign is_meta   = (phase_q == PH_MDATA);

	// decode one byte
	always_comb begin
		phase_n   = phase_q;
		bcnt_n    = bcnt_q;
		chunk_n   = chunk_dec;
		vlq_n     = vlq_q;
		rs_n      = rs_q;
		clock_n   = clock_q;
		trk_n     = trk_q;
		delta_n   = delta_q;
		held_n    = held_q;
		pay_n     = pay_q;
		hfmt_n    = hfmt_q;
		htrk_n    = htrk_q;
		res_valid = 1'b0;
		res       = '0;
		res.track_number   = trk_q;
		res.delta_ticks    = 32'(delta_q);
		res.absolute_ticks = 32'(clock_q);

		unique case (phase_q)
			PH_HDR: begin
				bcnt_n = bcnt_q + 4'd1;
				if (bcnt_q < 4'd8) begin
					if (in_byte != mfsp_pkg::hdr_magic(bcnt_q[2:0])) begin
						phase_n        = PH_HALT;
						res_valid      = 1'b1;
						res.kind       = mfsp_pkg::KIND_ERROR;
						res.error_code = mfsp_pkg::ERR_HDR;
					end
				end else if (bcnt_q < 4'd10) begin
					hfmt_n = {hfmt_q[7:0], in_byte};
				end else if (bcnt_q < 4'd12) begin
					htrk_n = {htrk_q[7:0], in_byte};
				end else if (bcnt_q == 4'd12) begin
					held_n = in_byte;
				end else begin
					res_valid          = 1'b1;
					res.kind           = mfsp_pkg::KIND_HEADER;
					res.track_number   = htrk_q;
					res.delta_ticks    = '0;
					res.absolute_ticks = '0;
					res.file_format    = hfmt_q;
					res.tick_division  = {held_q, in_byte};
					held_n             = '0;
					phase_n            = PH_CMAGIC;
					bcnt_n             = '0;
				end
			end
			PH_CMAGIC: begin
				if (in_byte != mfsp_pkg::trk_magic(bcnt_q[1:0])) begin
					phase_n        = PH_HALT;
					res_valid      = 1'b1;
					res.kind       = mfsp_pkg::KIND_ERROR;
					res.error_code = mfsp_pkg::ERR_CHUNK;
				end else if (bcnt_q >= 4'd3) begin
					phase_n = PH_CLEN;
					bcnt_n  = '0;
					chunk_n = '0;
				end else begin
					bcnt_n = bcnt_q + 4'd1;
				end
			end
			PH_CLEN: begin
				chunk_n = {chunk_q[23:0], in_byte};
				if (bcnt_q < 4'd3) begin
					bcnt_n = bcnt_q + 4'd1;
				end else begin
					clock_n            = '0;
					delta_n            = '0;
					rs_n               = '0;
					vlq_n              = '0;
					res_valid          = 1'b1;
					res.kind           = mfsp_pkg::KIND_TRACK;
					res.delta_ticks    = '0;
					res.absolute_ticks = '0;
					res.payload_length = chunk_n;
					if (chunk_n == '0) begin
						trk_n   = trk_q + 16'd1;
						phase_n = PH_CMAGIC;
						bcnt_n  = '0;
					end else begin
						phase_n = PH_DELTA;
					end
				end
			end
			PH_DELTA: begin
				vlq_n = vlq_take;
				if (!in_byte[7]) begin
					delta_n = vlq_take;
					clock_n = clock_q + vlq_take;
					phase_n = PH_STATUS;
				end
			end
			PH_STATUS, PH_DATA1: begin
				if (phase_q == PH_STATUS && in_byte[7]) begin
					if (in_byte == mfsp_pkg::ST_SYSEX || in_byte == mfsp_pkg::ST_ESCAPE) begin
						rs_n    = '0;
						held_n  = in_byte;
						vlq_n   = '0;
						phase_n = PH_XLEN;
					end else if (in_byte == mfsp_pkg::ST_META) begin
						rs_n    = '0;
						phase_n = PH_MTYPE;
					end else if (in_byte[7:4] == 4'hF) begin
						phase_n        = PH_HALT;
						res_valid      = 1'b1;
						res.kind       = mfsp_pkg::KIND_ERROR;
						res.error_code = mfsp_pkg::ERR_STATUS;
					end else begin
						rs_n    = in_byte;
						phase_n = PH_DATA1;
					end
				end else if (phase_q == PH_STATUS && rs_q == '0) begin
					phase_n        = PH_HALT;
					res_valid      = 1'b1;
					res.kind       = mfsp_pkg::KIND_ERROR;
					res.error_code = mfsp_pkg::ERR_STATUS;
				end else if (rs_q[7:4] == mfsp_pkg::HI_PROG ||
						rs_q[7:4] == mfsp_pkg::HI_PRESS) begin
					res_valid       = 1'b1;
					res.kind        = mfsp_pkg::KIND_CHANNEL;
					res.status_byte = rs_q;
					res.first_data  = in_byte;
					if (chunk_dec == '0) begin
						trk_n   = trk_q + 16'd1;
						phase_n = PH_CMAGIC;
						bcnt_n  = '0;
					end else begin
						phase_n = PH_DELTA;
						vlq_n   = '0;
					end
				end else begin
					held_n  = in_byte;
					phase_n = PH_DATA2;
				end
			end
			PH_DATA2: begin
				res_valid       = 1'b1;
				res.kind        = mfsp_pkg::KIND_CHANNEL;
				res.status_byte = rs_q;
				res.first_data  = held_q;
				res.second_data = in_byte;
				if (chunk_dec == '0) begin
					trk_n   = trk_q + 16'd1;
					phase_n = PH_CMAGIC;
					bcnt_n  = '0;
				end else begin
					phase_n = PH_DELTA;
					vlq_n   = '0;
				end
			end
			PH_MTYPE: begin
				held_n  = in_byte;
				vlq_n   = '0;
				phase_n = PH_MLEN;
			end
			PH_MLEN, PH_XLEN: begin
				vlq_n = vlq_take;
				if (!in_byte[7]) begin
					pay_n              = vlq_take;
					res_valid          = 1'b1;
					res.payload_length = 32'(vlq_take);
					if (phase_q == PH_MLEN) begin
						res.kind        = mfsp_pkg::KIND_META;
						res.status_byte = mfsp_pkg::ST_META;
						res.first_data  = held_q;
						phase_n         = PH_MDATA;
					end else begin
						res.kind        = mfsp_pkg::KIND_SYSEX;
						res.status_byte = held_q;
						phase_n         = PH_XDATA;
					end
					if (vlq_take == '0) begin
						if (chunk_dec == '0) begin
							trk_n   = trk_q + 16'd1;
							phase_n = PH_CMAGIC;
							bcnt_n  = '0;
						end else begin
							phase_n = PH_DELTA;
							vlq_n   = '0;
						end
					end
				end
			end
			PH_MDATA, PH_XDATA: begin
				pay_n            = (pay_q != '0) ? pay_q - TIME_WIDTH'(1) : pay_q;
				res_valid        = 1'b1;
				res.kind         = mfsp_pkg::KIND_PAYLOAD;
				res.status_byte  = is_meta ? mfsp_pkg::ST_META : held_q;
				res.first_data   = in_byte;
				res.last_payload = (pay_n == '0);
				if (pay_n == '0) begin
					if (chunk_dec == '0) begin
						trk_n   = trk_q + 16'd1;
						phase_n = PH_CMAGIC;
						bcnt_n  = '0;
					end else begin
						phase_n = PH_DELTA;
						vlq_n   = '0;
					end
				end
			end
			PH_HALT: begin
				chunk_n = chunk_q;
			end
			default: begin
				chunk_n = chunk_q;
			end
		endcase
	end

	// halt is sticky until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("parser left halt");
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |-> !res_valid)
		else $error("result after halt");
	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		take && res_valid && res.kind == mfsp_pkg::KIND_ERROR |=> phase_q == PH_HALT)
		else $error("error did not halt");

endmodule
`default_nettype wire

@@ src/mfsp_queue.sv @@
`default_nettype none
module mfsp_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire mfsp_pkg::result_t  push_data,
	output logic                    full,
	output logic                    pop_valid,
	input  wire logic               pop,
	output mfsp_pkg::result_t       pop_data
);

	mfsp_pkg::result_t                 mem_q [mfsp_pkg::QUEUE_DEPTH];
	logic [mfsp_pkg::QPTR_W-1:0]       wr_q, rd_q;
	logic [mfsp_pkg::QCNT_W-1:0]       cnt_q;
	logic                              do_pop;

	assign full      = (cnt_q == mfsp_pkg::QCNT_W'(mfsp_pkg::QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign do_pop    = pop && pop_valid;
	assign pop_data  = mem_q[rd_q];

	// store results
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + mfsp_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + mfsp_pkg::QPTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + mfsp_pkg::QCNT_W'(1);
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - mfsp_pkg::QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mfsp_pkg::QCNT_W'(mfsp_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0 && cnt_q != mfsp_pkg::QCNT_W'(mfsp_pkg::QUEUE_DEPTH)) |->
		(mfsp_pkg::QPTR_W'(wr_q - rd_q) == mfsp_pkg::QPTR_W'(cnt_q)))
		else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

@@ src/midi_file_stream_parser.sv @@
// Byte-serial Standard MIDI File parser.
// Input channel: in_valid / in_ready / in_byte, one file byte per transfer.
// Output channel: out_valid / out_ready and one port per result field;
// a byte causes at most one result (header, track start, channel message,
// meta or sysex start, payload byte, error).
// Throughput: one byte per cycle while the result queue has room. The
// front parser classifies a byte in the cycle it is taken and writes any
// result into a four-entry queue; the queue head drives the outputs.
// A result is registered in the queue before it reaches the outputs.
// When the receiver stalls, results collect in the queue and in_ready
// drops once four are waiting; bytes without a result still need room.
// After an error result the parser ignores every byte until reset.
// Reset (arst_n low) empties the queue and returns the parser to the
// start of the file header.
`default_nettype none
module midi_file_stream_parser #(
	parameter int unsigned TIME_WIDTH = mfsp_pkg::TIME_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [15:0]      track_number,
	output logic [31:0]      delta_ticks,
	output logic [31:0]      absolute_ticks,
	output logic [7:0]       status_byte,
	output logic [7:0]       first_data,
	output logic [7:0]       second_data,
	output logic [31:0]      payload_length,
	output logic [1:0]       error_code,
	output logic [15:0]      file_format,
	output logic [15:0]      tick_division,
	output logic             last_payload
);

	mfsp_pkg::result_t res, head;
	logic              res_valid, take, full;

	assign in_ready = !full;
	assign take     = in_valid && in_ready;

	mfsp_parser #(.TIME_WIDTH(TIME_WIDTH)) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (in_byte),
		.res       (res),
		.res_valid (res_valid)
	);

	mfsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && res_valid),
		.push_data (res),
		.full      (full),
		.pop_valid (out_valid),
		.pop       (out_ready),
		.pop_data  (head)
	);

	assign kind           = head.kind;
	assign track_number   = head.track_number;
	assign delta_ticks    = head.delta_ticks;
	assign absolute_ticks = head.absolute_ticks;
	assign status_byte    = head.status_byte;
	assign first_data     = head.first_data;
	assign second_data    = head.second_data;
	assign payload_length = head.payload_length;
	assign error_code     = head.error_code;
	assign file_format    = head.file_format;
	assign tick_division  = head.tick_division;
	assign last_payload   = head.last_payload;

endmodule
`default_nettype wire

@@ tb/midi_file_stream_parser_chk.sv @@
`timescale 1ns / 100ps
module midi_file_stream_parser_chk (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  in_byte,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [15:0] track_number,
	input  wire logic [31:0] delta_ticks,
	input  wire logic [31:0] absolute_ticks,
	input  wire logic [7:0]  status_byte,
	input  wire logic [7:0]  first_data,
	input  wire logic [7:0]  second_data,
	input  wire logic [31:0] payload_length,
	input  wire logic [1:0]  error_code,
	input  wire logic [15:0] file_format,
	input  wire logic [15:0] tick_division,
	input  wire logic        last_payload,
	output int               fail_count,
	output int               pending
);

	typedef enum logic [3:0] {
		S_HDR, S_CMAGIC, S_CLEN, S_DELTA, S_STATUS, S_DATA1, S_DATA2,
		S_MTYPE, S_MLEN, S_MDATA, S_XLEN, S_XDATA, S_HALT
	} phase_t;

	localparam logic [7:0] FILE_MAGIC [8] = '{8'h4D, 8'h54, 8'h68, 8'h64,
		8'h00, 8'h00, 8'h00, 8'h06};
	localparam logic [7:0] TRACK_MAGIC [4] = '{8'h4D, 8'h54, 8'h72, 8'h6B};

	phase_t      phase;
	logic [3:0]  idx_cnt;
	logic [31:0] chunk_left;
	logic [31:0] vlq_acc;
	logic [7:0]  run_status;
	logic [31:0] abs_clock;
	logic [15:0] trk_idx;
	logic [31:0] ev_delta;
	logic [7:0]  held_byte;
	logic [31:0] pay_left;
	logic [15:0] hdr_fmt;
	logic [15:0] hdr_trk;

	mfsp_pkg::result_t expected_results [$];

	assign pending = expected_results.size();

	function automatic mfsp_pkg::result_t make_result(logic [2:0] k, logic [7:0] st,
			logic [7:0] d1, logic [7:0] d2, logic [31:0] len, logic [1:0] err, logic last);
		mfsp_pkg::result_t r;
		r = '0;
		r.kind           = k;
		r.track_number   = trk_idx;
		r.delta_ticks    = ev_delta;
		r.absolute_ticks = abs_clock;
		r.status_byte    = st;
		r.first_data     = d1;
		r.second_data    = d2;
		r.payload_length = len;
		r.error_code     = err;
		r.last_payload   = last;
		return r;
	endfunction

	// queue a prediction behind the others
	task automatic add_expected(mfsp_pkg::result_t r);
		expected_results.insert(expected_results.size(), r);
	endtask

	// close an event: next track or next delta
	task automatic close_event();
		if (chunk_left == '0) begin
			trk_idx = trk_idx + 16'd1;
			phase   = S_CMAGIC;
			idx_cnt = '0;
		end else begin
			phase   = S_DELTA;
			vlq_acc = '0;
		end
	endtask

	task automatic halt_with(logic [1:0] code);
		phase = S_HALT;
		add_expected(make_result(mfsp_pkg::KIND_ERROR, '0, '0, '0, '0, code, 1'b0));
	endtask

	// advance the parser model by one byte
	task automatic parse_byte(logic [7:0] b);
		logic [3:0]        idx;
		mfsp_pkg::result_t r;
		bit                data1;
		idx   = idx_cnt;
		data1 = 0;
		if (phase >= S_DELTA && phase <= S_XDATA && chunk_left != '0)
			chunk_left = chunk_left - 32'd1;
		case (phase)
			S_HDR: begin
				if (idx < 4'd8) begin
					if (b != FILE_MAGIC[idx[2:0]]) begin
						halt_with(mfsp_pkg::ERR_HDR);
						return;
					end
				end else if (idx < 4'd10) begin
					hdr_fmt = {hdr_fmt[7:0], b};
				end else if (idx < 4'd12) begin
					hdr_trk = {hdr_trk[7:0], b};
				end else if (idx == 4'd12) begin
					held_byte = b;
				end else begin
					r = make_result(mfsp_pkg::KIND_HEADER, '0, '0, '0, '0,
						mfsp_pkg::ERR_NONE, 1'b0);
					r.track_number   = hdr_trk;
					r.delta_ticks    = '0;
					r.absolute_ticks = '0;
					r.file_format    = hdr_fmt;
					r.tick_division  = {held_byte, b};
					add_expected(r);
					held_byte = '0;
					phase     = S_CMAGIC;
					idx_cnt   = '0;
					return;
				end
				idx_cnt = idx + 4'd1;
			end
			S_CMAGIC: begin
				if (b != TRACK_MAGIC[idx[1:0]]) begin
					halt_with(mfsp_pkg::ERR_CHUNK);
					return;
				end
				if (idx >= 4'd3) begin
					phase      = S_CLEN;
					idx_cnt    = '0;
					chunk_left = '0;
				end else begin
					idx_cnt = idx + 4'd1;
				end
			end
			S_CLEN: begin
				chunk_left = {chunk_left[23:0], b};
				if (idx < 4'd3) begin
					idx_cnt = idx + 4'd1;
				end else begin
					abs_clock  = '0;
					ev_delta   = '0;
					run_status = '0;
					add_expected(make_result(mfsp_pkg::KIND_TRACK, '0, '0, '0, chunk_left,
						mfsp_pkg::ERR_NONE, 1'b0));
					vlq_acc = '0;
					close_event();
				end
			end
			S_DELTA: begin
				vlq_acc = {vlq_acc[24:0], b[6:0]};
				if (!b[7]) begin
					ev_delta  = vlq_acc;
					abs_clock = abs_clock + vlq_acc;
					phase     = S_STATUS;
				end
			end
			S_STATUS: begin
				if (b[7]) begin
					if (b == mfsp_pkg::ST_SYSEX || b == mfsp_pkg::ST_ESCAPE) begin
						run_status = '0;
						held_byte  = b;
						vlq_acc    = '0;
						phase      = S_XLEN;
					end else if (b == mfsp_pkg::ST_META) begin
						run_status = '0;
						phase      = S_MTYPE;
					end else if (b >= 8'hF0) begin
						halt_with(mfsp_pkg::ERR_STATUS);
					end else begin
						run_status = b;
						phase      = S_DATA1;
					end
				end else if (run_status == '0) begin
					halt_with(mfsp_pkg::ERR_STATUS);
				end else begin
					data1 = 1;
				end
			end
			S_DATA1: data1 = 1;
			S_DATA2: begin
				add_expected(make_result(mfsp_pkg::KIND_CHANNEL, run_status, held_byte, b,
					'0, mfsp_pkg::ERR_NONE, 1'b0));
				close_event();
			end
			S_MTYPE: begin
				held_byte = b;
				vlq_acc   = '0;
				phase     = S_MLEN;
			end
			S_MLEN, S_XLEN: begin
				vlq_acc = {vlq_acc[24:0], b[6:0]};
				if (!b[7]) begin
					pay_left = vlq_acc;
					if (phase == S_MLEN) begin
						add_expected(make_result(mfsp_pkg::KIND_META, mfsp_pkg::ST_META,
							held_byte, '0, pay_left, mfsp_pkg::ERR_NONE, 1'b0));
						phase = S_MDATA;
					end else begin
						add_expected(make_result(mfsp_pkg::KIND_SYSEX, held_byte, '0, '0,
							pay_left, mfsp_pkg::ERR_NONE, 1'b0));
						phase = S_XDATA;
					end
					if (pay_left == '0) close_event();
				end
			end
			S_MDATA, S_XDATA: begin
				if (pay_left != '0) pay_left = pay_left - 32'd1;
				add_expected(make_result(mfsp_pkg::KIND_PAYLOAD,
					phase == S_MDATA ? mfsp_pkg::ST_META : held_byte, b, '0, '0,
					mfsp_pkg::ERR_NONE, pay_left == '0));
				if (pay_left == '0) close_event();
			end
			default: ;
		endcase
		// channel message data byte, either direct or under running status
		if (data1) begin
			if (run_status[7:4] == mfsp_pkg::HI_PROG || run_status[7:4] == mfsp_pkg::HI_PRESS)
			begin
				add_expected(make_result(mfsp_pkg::KIND_CHANNEL, run_status, b, '0, '0,
					mfsp_pkg::ERR_NONE, 1'b0));
				close_event();
			end else begin
				held_byte = b;
				phase     = S_DATA2;
			end
		end
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("field %s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		mfsp_pkg::result_t e;
		if (!arst_n) begin
			phase      = S_HDR;
			idx_cnt    = '0;
			chunk_left = '0;
			vlq_acc    = '0;
			run_status = '0;
			abs_clock  = '0;
			trk_idx    = '0;
			ev_delta   = '0;
			held_byte  = '0;
			pay_left   = '0;
			hdr_fmt    = '0;
			hdr_trk    = '0;
			expected_results.delete();
		end else begin
			// compare an outgoing transfer with the oldest prediction
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no prediction: kind 0x%0h", kind);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					check_field("kind", 32'(e.kind), 32'(kind));
					check_field("track_number", 32'(e.track_number), 32'(track_number));
					check_field("delta_ticks", e.delta_ticks, delta_ticks);
					check_field("absolute_ticks", e.absolute_ticks, absolute_ticks);
					check_field("status_byte", 32'(e.status_byte), 32'(status_byte));
					check_field("first_data", 32'(e.first_data), 32'(first_data));
					check_field("second_data", 32'(e.second_data), 32'(second_data));
					check_field("payload_length", e.payload_length, payload_length);
					check_field("error_code", 32'(e.error_code), 32'(error_code));
					check_field("file_format", 32'(e.file_format), 32'(file_format));
					check_field("tick_division", 32'(e.tick_division), 32'(tick_division));
					check_field("last_payload", 32'(e.last_payload), 32'(last_payload));
				end
			end
			if (in_valid && in_ready) parse_byte(in_byte);
		end
	end

endmodule

@@ tb/midi_file_stream_parser_tb.sv @@
`timescale 1ns / 100ps
module midi_file_stream_parser_tb;

	localparam int STALL_LIMIT = 2000;
	localparam int BYTE_TARGET = 800;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  kind;
	logic [15:0] track_number;
	logic [31:0] delta_ticks;
	logic [31:0] absolute_ticks;
	logic [7:0]  status_byte;
	logic [7:0]  first_data;
	logic [7:0]  second_data;
	logic [31:0] payload_length;
	logic [1:0]  error_code;
	logic [15:0] file_format;
	logic [15:0] tick_division;
	logic        last_payload;

	int fail_count;
	int pending;
	int bytes_sent = 0;
	bit quiet = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	logic [7:0] track_body [$];
	logic [7:0] gen_status;
	int         last_start;

	midi_file_stream_parser dut (.*);
	midi_file_stream_parser_chk chk (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// receiver: stall in random bursts, never in the quiet tail
	always @(posedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 15);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog: end the run when nothing transfers for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("midi_file_stream_parser regression: fail");
			$finish;
		end
	end

	// drive one byte and hold it until the transfer
	task automatic send_byte(logic [7:0] b);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
		if (bytes_sent > BYTE_TARGET * 4 / 5) quiet = 1;
	endtask

	// add one byte at the end of the track body
	task automatic append_byte(logic [7:0] b);
		track_body.insert(track_body.size(), b);
	endtask

	task automatic push_vlq(logic [31:0] v, int pad);
		logic [7:0] grp [$];
		grp.push_front({1'b0, v[6:0]});
		v = v >> 7;
		while (v != 0) begin
			grp.push_front({1'b1, v[6:0]});
			v = v >> 7;
		end
		repeat (pad) append_byte(8'h80);
		foreach (grp[i]) append_byte(grp[i]);
	endtask

	// delta time: mostly short, sometimes wide, sometimes overlong and wrapping
	task automatic push_delta();
		int m;
		int n;
		m = $urandom_range(0, 9);
		if (m < 6) begin
			push_vlq($urandom_range(0, 127), 0);
		end else if (m < 8) begin
			push_vlq($urandom & 32'h0FFF_FFFF, $urandom_range(0, 2));
		end else begin
			n = $urandom_range(5, 7);
			repeat (n) append_byte(8'($urandom_range(0, 255)) | 8'h80);
			append_byte(8'($urandom_range(0, 127)));
		end
	endtask

	// append one event: 0 channel, 1 running status, 2 meta, 3 sysex
	task automatic push_event(int ek);
		logic [7:0] st;
		int         len;
		last_start = track_body.size();
		push_delta();
		if (ek == 1 && gen_status == 0) ek = 0;
		case (ek)
			0, 1: begin
				if (ek == 0) begin
					gen_status = 8'($urandom_range(8'h80, 8'hEF));
					append_byte(gen_status);
				end
				// under running status the first data byte must look like data
				append_byte(ek == 1 ? 8'($urandom_range(0, 127)) : 8'($urandom_range(0, 255)));
				if (gen_status[7:4] != mfsp_pkg::HI_PROG && gen_status[7:4] != mfsp_pkg::HI_PRESS)
					append_byte(8'($urandom_range(0, 255)));
			end
			default: begin
				gen_status = 0;
				st = (ek == 2) ? mfsp_pkg::ST_META
					: ($urandom_range(0, 1) ? mfsp_pkg::ST_SYSEX : mfsp_pkg::ST_ESCAPE);
				append_byte(st);
				if (ek == 2) append_byte(8'($urandom_range(0, 255)));
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
					: $urandom_range(0, 6);
				push_vlq(32'(len), $urandom_range(0, 3) == 0 ? 1 : 0);
				repeat (len) append_byte(8'($urandom_range(0, 255)));
			end
		endcase
	endtask

	task automatic send_track_magic();
		send_byte(8'h4D);
		send_byte(8'h54);
		send_byte(8'h72);
		send_byte(8'h6B);
	endtask

	// send the built body as one chunk; the length may stop inside the last event
	task automatic send_track();
		logic [31:0] len;
		len = track_body.size();
		if (len != 0 && $urandom_range(0, 4) == 0)
			len = $urandom_range(last_start + 1, track_body.size());
		send_track_magic();
		send_byte(len[31:24]);
		send_byte(len[23:16]);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		foreach (track_body[i]) send_byte(track_body[i]);
		track_body.delete();
	endtask

	task automatic send_header(logic [15:0] fmt, logic [15:0] trk, logic [15:0] div);
		send_byte(8'h4D);
		send_byte(8'h54);
		send_byte(8'h68);
		send_byte(8'h64);
		repeat (3) send_byte(8'h00);
		send_byte(8'h06);
		send_byte(fmt[15:8]);
		send_byte(fmt[7:0]);
		send_byte(trk[15:8]);
		send_byte(trk[7:0]);
		send_byte(div[15:8]);
		send_byte(div[7:0]);
	endtask

	initial begin
		int         ending;
		int         n;
		int         pos;
		logic [7:0] b;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		ending = $urandom_range(0, 7);
		if (ending == 0) begin
			// bad file magic: corrupt one byte of the header
			pos = $urandom_range(0, 7);
			for (int i = 0; i < 8; i++) begin
				b = (i < 4) ? 8'("MThd" >> (8 * (3 - i))) : ((i == 7) ? 8'h06 : 8'h00);
				send_byte(i == pos ? b ^ (8'h01 << $urandom_range(0, 7)) : b);
			end
		end else begin
			case ($urandom_range(0, 2))
				0: send_header(16'h0000, 16'h0000, 16'h0000);
				1: send_header(16'hFFFF, 16'hFFFF, 16'hFFFF);
				default: send_header(16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			// zero-length chunk, then every kind of event at least once
			send_track();
			gen_status = 0;
			push_event(0);
			push_event(1);
			push_event(2);
			push_event(3);
			push_event(1);
			push_event(0);
			send_track();
			while (bytes_sent < BYTE_TARGET) begin
				gen_status = 0;
				n = $urandom_range(1, 8);
				repeat (n) push_event($urandom_range(0, 3));
				send_track();
			end
			if (ending < 4) begin
				// bad chunk magic
				pos = $urandom_range(0, 3);
				for (int i = 0; i < 4; i++) begin
					b = 8'("MTrk" >> (8 * (3 - i)));
					send_byte(i == pos ? b ^ (8'h01 << $urandom_range(0, 7)) : b);
				end
			end else begin
				// unusable status: system byte, or data with no running status
				send_track_magic();
				send_byte(8'h00);
				send_byte(8'h00);
				send_byte(8'h00);
				send_byte(8'h40);
				send_byte(8'h00);
				if ($urandom_range(0, 1)) begin
					do b = 8'($urandom_range(8'hF1, 8'hFE)); while (b == mfsp_pkg::ST_ESCAPE);
					send_byte(b);
				end else begin
					send_byte(8'($urandom_range(0, 127)));
				end
			end
		end
		// bytes after an error are ignored
		repeat (20) send_byte(8'($urandom_range(0, 255)));
		while (bytes_sent < BYTE_TARGET) send_byte(8'($urandom_range(0, 255)));
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("midi_file_stream_parser regression: pass");
		end else begin
			$display("midi_file_stream_parser regression: fail");
		end
		$finish;
	end

endmodule
